// File: hdl/touch_gesture_lamp_controller_unit_defines.svh
// Assertion helpers for the lamp controller RTL.
`ifndef TOUCH_GESTURE_LAMP_CONTROLLER_UNIT_DEFINES_SVH
`define TOUCH_GESTURE_LAMP_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TGLC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tglc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TGLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tglc: next-cycle check failed");

`endif

// File: hdl/tglc_pkg.sv
package tglc_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_HOLD_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_HOLD_REPEAT  = 2'd1;
  localparam logic [1:0] REG_DOUBLE_CLICK = 2'd2;

  localparam logic [CFG_W-1:0] HOLD_TIMEOUT_RST = 16'd500;
  localparam logic [CFG_W-1:0] HOLD_REPEAT_RST  = 16'd100;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd400;

  // Event kinds
  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_BREATHE = 2'd3;

  // Pending release actions
  localparam logic [1:0] REL_CLICK = 2'd0;
  localparam logic [1:0] REL_HOLD  = 2'd1;
  localparam logic [1:0] REL_SKIP  = 2'd2;

  // Lamp modes
  localparam logic [2:0] LAMP_STEADY  = 3'd0;
  localparam logic [2:0] LAMP_FULL    = 3'd1;
  localparam logic [2:0] LAMP_BREATHE = 3'd2;
  localparam logic [2:0] LAMP_FLASH   = 3'd3;
  localparam logic [2:0] LAMP_EERIE   = 3'd4;
  localparam logic [2:0] LAMP_SHAKE   = 3'd5;

  // Lamp commands
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_ON_MIN = 3'd1;
  localparam logic [2:0] CMD_DIM    = 3'd2;
  localparam logic [2:0] CMD_ON     = 3'd3;
  localparam logic [2:0] CMD_OFF    = 3'd4;
  localparam logic [2:0] CMD_MAXDIM = 3'd5;
  localparam logic [2:0] CMD_SAVE   = 3'd6;
  localparam logic [2:0] CMD_QUAKE  = 3'd7;

  // Strobe rates
  localparam logic [5:0] STROBE_5  = 6'd5;
  localparam logic [5:0] STROBE_10 = 6'd10;
  localparam logic [5:0] STROBE_20 = 6'd20;
  localparam logic [5:0] STROBE_30 = 6'd30;
  localparam logic [5:0] STROBE_40 = 6'd40;

  typedef struct packed {
    logic [CFG_W-1:0] hold_timeout_ms;
    logic [CFG_W-1:0] hold_repeat_ms;
    logic [CFG_W-1:0] double_click_ms;
  } cfg_t;

  function automatic logic [5:0] next_strobe(input logic [5:0] rate);
    logic [5:0] nxt;
    if (rate < STROBE_10) nxt = STROBE_10;
    else if (rate < STROBE_20) nxt = STROBE_20;
    else if (rate < STROBE_30) nxt = STROBE_30;
    else if (rate < STROBE_40) nxt = STROBE_40;
    else nxt = STROBE_5;
    return nxt;
  endfunction

  // Advance modulo six; the unused codes six and seven wrap to bright and breathe.
  function automatic logic [2:0] next_mode(input logic [2:0] mode);
    logic [2:0] nxt;
    if (mode == LAMP_SHAKE) nxt = LAMP_STEADY;
    else if (mode > LAMP_SHAKE) nxt = mode - LAMP_SHAKE;
    else nxt = mode + 3'd1;
    return nxt;
  endfunction

endpackage

// File: hdl/tglc_if.sv
interface tglc_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] now_ms;

  modport source (output valid, output kind, output now_ms, input ready);
  modport sink   (input valid, input kind, input now_ms, output ready);
endinterface

interface tglc_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] lamp_command;
  logic [2:0] lamp_mode;
  logic [5:0] strobe_rate_hz;

  modport source (output valid, output lamp_command, output lamp_mode,
                  output strobe_rate_hz, input ready);
  modport sink   (input valid, input lamp_command, input lamp_mode,
                  input strobe_rate_hz, output ready);
endinterface

// File: hdl/tglc_regs.sv
module tglc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tglc_pkg::PADDR_W-1:0]  paddr,
  input  logic [tglc_pkg::PDATA_W-1:0]  pwdata,
  output logic [tglc_pkg::PDATA_W-1:0]  prdata,
  output tglc_pkg::cfg_t                cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[tglc_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_timeout_ms <= tglc_pkg::HOLD_TIMEOUT_RST;
      cfg.hold_repeat_ms  <= tglc_pkg::HOLD_REPEAT_RST;
      cfg.double_click_ms <= tglc_pkg::DOUBLE_CLICK_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        tglc_pkg::REG_HOLD_TIMEOUT: cfg.hold_timeout_ms <= pwdata[tglc_pkg::CFG_W-1:0];
        tglc_pkg::REG_HOLD_REPEAT:  cfg.hold_repeat_ms  <= pwdata[tglc_pkg::CFG_W-1:0];
        tglc_pkg::REG_DOUBLE_CLICK: cfg.double_click_ms <= pwdata[tglc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tglc_pkg::REG_HOLD_TIMEOUT: prdata = {16'd0, cfg.hold_timeout_ms};
      tglc_pkg::REG_HOLD_REPEAT:  prdata = {16'd0, cfg.hold_repeat_ms};
      tglc_pkg::REG_DOUBLE_CLICK: prdata = {16'd0, cfg.double_click_ms};
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: hdl/touch_gesture_lamp_controller_unit.sv
// An accepted event goes to the input register, its result to the result register.
// Throughput: one event per cycle while the sink takes results; each event is
// resolved in one add/compare pass between the input and result registers.
// Reset (rst, synchronous): clears both valid flags, loads the register
// defaults (500/100/400 ms) and returns the lamp state to off, normal mode,
// strobe 5 Hz, click pending, with both time stamps at zero.
`include "touch_gesture_lamp_controller_unit_defines.svh"

module touch_gesture_lamp_controller_unit (
  input  logic                          clk,
  input  logic                          rst,
  tglc_event_if.sink                    events,
  tglc_result_if.source                 results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tglc_pkg::PADDR_W-1:0]  paddr,
  input  logic [tglc_pkg::PDATA_W-1:0]  pwdata,
  output logic [tglc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  tglc_pkg::cfg_t cfg;

  // input register
  logic        in_valid;
  logic [1:0]  in_kind;
  logic [31:0] in_now;

  // result register
  logic        out_valid;
  logic [2:0]  out_cmd;
  logic [2:0]  out_mode;
  logic [5:0]  out_rate;

  // lamp state
  logic [31:0] press_time, press_time_next;
  logic [31:0] last_click_time, last_click_time_next;
  logic [1:0]  pending_release, pending_release_next;
  logic [2:0]  mode_reg, mode_reg_next;
  logic        light_is_lit, light_is_lit_next;
  logic [5:0]  strobe_rate, strobe_rate_next;
  logic [2:0]  cmd_next;

  logic        take;
  logic        out_free;
  logic        step;
  logic [31:0] hold_limit;
  logic        hold_due;
  logic [31:0] rearm_time;
  logic [31:0] click_gap;
  logic [2:0]  mode_adv;

  logic        strobe_legal;
  logic        save_due;
  logic        off_due;
  logic        lamp_cleared;

  tglc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  assign out_free      = !out_valid || results.ready;
  assign step          = in_valid && out_free;
  assign events.ready  = !in_valid || out_free;
  assign take          = events.valid && events.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (events.ready) begin
      in_valid <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_kind <= events.kind;
      in_now  <= events.now_ms;
    end
  end

  always_comb begin
    hold_limit = press_time + {16'd0, cfg.hold_timeout_ms};
    hold_due   = in_now > hold_limit;
    rearm_time = in_now - ({16'd0, cfg.hold_timeout_ms} - {16'd0, cfg.hold_repeat_ms});
    click_gap  = in_now - last_click_time;
    mode_adv   = tglc_pkg::next_mode(mode_reg);

    press_time_next      = press_time;
    last_click_time_next = last_click_time;
    pending_release_next = pending_release;
    mode_reg_next        = mode_reg;
    light_is_lit_next    = light_is_lit;
    strobe_rate_next     = strobe_rate;
    cmd_next             = tglc_pkg::CMD_NONE;

    unique case (in_kind)
      tglc_pkg::KIND_PRESS: begin
        press_time_next      = in_now;
        pending_release_next = tglc_pkg::REL_CLICK;
      end
      tglc_pkg::KIND_TICK: begin
        if (hold_due) begin
          case (mode_reg) inside
            tglc_pkg::LAMP_STEADY, tglc_pkg::LAMP_FULL: begin
              if (!light_is_lit) begin
                cmd_next          = tglc_pkg::CMD_ON_MIN;
                light_is_lit_next = 1'b1;
              end else begin
                cmd_next = tglc_pkg::CMD_DIM;
              end
              pending_release_next = tglc_pkg::REL_HOLD;
              press_time_next      = rearm_time;
            end
            tglc_pkg::LAMP_FLASH: begin
              strobe_rate_next     = tglc_pkg::next_strobe(strobe_rate);
              pending_release_next = tglc_pkg::REL_SKIP;
              press_time_next      = rearm_time;
            end
            tglc_pkg::LAMP_SHAKE: begin
              cmd_next             = tglc_pkg::CMD_QUAKE;
              pending_release_next = tglc_pkg::REL_SKIP;
              press_time_next      = rearm_time;
            end
            default: ;
          endcase
        end
      end
      tglc_pkg::KIND_RELEASE: begin
        case (pending_release)
          tglc_pkg::REL_CLICK: begin
            if (light_is_lit) begin
              if (click_gap < {16'd0, cfg.double_click_ms}) begin
                mode_reg_next = mode_adv;
                if (mode_adv == tglc_pkg::LAMP_FULL) cmd_next = tglc_pkg::CMD_MAXDIM;
              end else begin
                cmd_next          = tglc_pkg::CMD_OFF;
                light_is_lit_next = 1'b0;
                mode_reg_next     = tglc_pkg::LAMP_STEADY;
              end
            end else begin
              cmd_next          = tglc_pkg::CMD_ON;
              light_is_lit_next = 1'b1;
            end
            last_click_time_next = in_now;
          end
          tglc_pkg::REL_HOLD: cmd_next = tglc_pkg::CMD_SAVE;
          default: ;
        endcase
      end
      tglc_pkg::KIND_BREATHE: begin
        pending_release_next = tglc_pkg::REL_SKIP;
        mode_reg_next        = tglc_pkg::LAMP_BREATHE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_time      <= '0;
      last_click_time <= '0;
      pending_release <= tglc_pkg::REL_CLICK;
      mode_reg        <= tglc_pkg::LAMP_STEADY;
      light_is_lit    <= 1'b0;
      strobe_rate     <= tglc_pkg::STROBE_5;
    end else if (step) begin
      press_time      <= press_time_next;
      last_click_time <= last_click_time_next;
      pending_release <= pending_release_next;
      mode_reg        <= mode_reg_next;
      light_is_lit    <= light_is_lit_next;
      strobe_rate     <= strobe_rate_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  // hold the result while the sink stalls
  always_ff @(posedge clk) begin
    if (step) begin
      out_cmd  <= cmd_next;
      out_mode <= mode_reg_next;
      out_rate <= strobe_rate_next;
    end
  end

  assign results.valid          = out_valid;
  assign results.lamp_command   = out_cmd;
  assign results.lamp_mode      = out_mode;
  assign results.strobe_rate_hz = out_rate;

  assign strobe_legal = (strobe_rate == tglc_pkg::STROBE_5) ||
                        (strobe_rate == tglc_pkg::STROBE_10) ||
                        (strobe_rate == tglc_pkg::STROBE_20) ||
                        (strobe_rate == tglc_pkg::STROBE_30) ||
                        (strobe_rate == tglc_pkg::STROBE_40);
  assign save_due     = step && (in_kind == tglc_pkg::KIND_RELEASE) &&
                        (pending_release == tglc_pkg::REL_HOLD);
  assign off_due      = step && (cmd_next == tglc_pkg::CMD_OFF);
  assign lamp_cleared = !light_is_lit && (mode_reg == tglc_pkg::LAMP_STEADY) &&
                        (out_mode == tglc_pkg::LAMP_STEADY);

  `TGLC_ASSERT_IMPLIES(a_mode_range, clk, rst, 1'b1, mode_reg <= tglc_pkg::LAMP_SHAKE)

  `TGLC_ASSERT_IMPLIES(a_strobe_set, clk, rst, 1'b1, strobe_legal)

  `TGLC_ASSERT_NEXT(a_release_save, clk, rst, save_due, out_valid && out_cmd == tglc_pkg::CMD_SAVE)

  `TGLC_ASSERT_NEXT(a_off_resets, clk, rst, off_due, lamp_cleared)

endmodule

// File: verif/touch_gesture_lamp_controller_unit_tb.sv
module touch_gesture_lamp_controller_unit_tb;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [2:0] command;
    logic [2:0] mode;
    logic [5:0] rate_hz;
  } lamp_result_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [tglc_pkg::PADDR_W-1:0] paddr;
  logic [tglc_pkg::PDATA_W-1:0] pwdata;
  logic [tglc_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  tglc_event_if  ev_if ();
  tglc_result_if res_if ();

  touch_gesture_lamp_controller_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .events  (ev_if),
    .results (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Timing registers as the lamp sees them
  logic [tglc_pkg::CFG_W-1:0] hold_timeout_cfg = tglc_pkg::HOLD_TIMEOUT_RST;
  logic [tglc_pkg::CFG_W-1:0] hold_repeat_cfg  = tglc_pkg::HOLD_REPEAT_RST;
  logic [tglc_pkg::CFG_W-1:0] double_click_cfg = tglc_pkg::DOUBLE_CLICK_RST;

  // Lamp state mirror
  logic [31:0] pad_down_ms    = '0;
  logic [31:0] last_tap_ms    = '0;
  logic [1:0]  release_action = tglc_pkg::REL_CLICK;
  logic [2:0]  lamp_mode_q    = tglc_pkg::LAMP_STEADY;
  logic        lamp_lit       = 1'b0;
  logic [5:0]  strobe_hz      = tglc_pkg::STROBE_5;

  lamp_result_t expected_lamp_q[$];
  int           mismatch_count = 0;
  int           stall_cycles   = 0;
  int           events_sent    = 0;
  logic         steady_flow    = 1'b0;
  logic [31:0]  wall_ms        = 32'd1000;

  function automatic lamp_result_t lamp_step(input logic [1:0] kind, input logic [31:0] stamp);
    logic [2:0]  command;
    logic [31:0] due_ms;
    logic [31:0] rearm_back;
    logic [31:0] tap_gap;
    command    = tglc_pkg::CMD_NONE;
    due_ms     = pad_down_ms + 32'(hold_timeout_cfg);
    rearm_back = 32'(hold_timeout_cfg) - 32'(hold_repeat_cfg);
    tap_gap    = stamp - last_tap_ms;
    case (kind)
      tglc_pkg::KIND_PRESS: begin
        pad_down_ms    = stamp;
        release_action = tglc_pkg::REL_CLICK;
      end
      tglc_pkg::KIND_TICK: begin
        if (stamp > due_ms) begin
          if (lamp_mode_q == tglc_pkg::LAMP_STEADY || lamp_mode_q == tglc_pkg::LAMP_FULL) begin
            command        = lamp_lit ? tglc_pkg::CMD_DIM : tglc_pkg::CMD_ON_MIN;
            lamp_lit       = 1'b1;
            release_action = tglc_pkg::REL_HOLD;
            pad_down_ms    = stamp - rearm_back;
          end else if (lamp_mode_q == tglc_pkg::LAMP_FLASH) begin
            if (strobe_hz < tglc_pkg::STROBE_10) strobe_hz = tglc_pkg::STROBE_10;
            else if (strobe_hz < tglc_pkg::STROBE_20) strobe_hz = tglc_pkg::STROBE_20;
            else if (strobe_hz < tglc_pkg::STROBE_30) strobe_hz = tglc_pkg::STROBE_30;
            else if (strobe_hz < tglc_pkg::STROBE_40) strobe_hz = tglc_pkg::STROBE_40;
            else strobe_hz = tglc_pkg::STROBE_5;
            release_action = tglc_pkg::REL_SKIP;
            pad_down_ms    = stamp - rearm_back;
          end else if (lamp_mode_q == tglc_pkg::LAMP_SHAKE) begin
            command        = tglc_pkg::CMD_QUAKE;
            release_action = tglc_pkg::REL_SKIP;
            pad_down_ms    = stamp - rearm_back;
          end
        end
      end
      tglc_pkg::KIND_RELEASE: begin
        if (release_action == tglc_pkg::REL_CLICK) begin
          if (!lamp_lit) begin
            command  = tglc_pkg::CMD_ON;
            lamp_lit = 1'b1;
          end else if (tap_gap < 32'(double_click_cfg)) begin
            lamp_mode_q = (lamp_mode_q == tglc_pkg::LAMP_SHAKE) ? tglc_pkg::LAMP_STEADY
                                                                : lamp_mode_q + 3'd1;
            if (lamp_mode_q == tglc_pkg::LAMP_FULL) command = tglc_pkg::CMD_MAXDIM;
          end else begin
            command     = tglc_pkg::CMD_OFF;
            lamp_lit    = 1'b0;
            lamp_mode_q = tglc_pkg::LAMP_STEADY;
          end
          last_tap_ms = stamp;
        end else if (release_action == tglc_pkg::REL_HOLD) begin
          command = tglc_pkg::CMD_SAVE;
        end
      end
      tglc_pkg::KIND_BREATHE: begin
        release_action = tglc_pkg::REL_SKIP;
        lamp_mode_q    = tglc_pkg::LAMP_BREATHE;
      end
    endcase
    return '{command, lamp_mode_q, strobe_hz};
  endfunction

  function automatic void flag_mismatch(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0d on %s: expected %0d, got %0d", mismatch_count, field, want, got);
  endfunction

  always @(posedge clk) res_if.ready <= steady_flow || ($urandom_range(0, 99) >= 19);

  always @(posedge clk) begin : check_results
    lamp_result_t got;
    lamp_result_t want;
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.lamp_command, res_if.lamp_mode, res_if.strobe_rate_hz};
        if (expected_lamp_q.size() == 0) begin
          flag_mismatch("lamp_command with nothing pending", 'x, got.command);
        end else begin
          want = expected_lamp_q.pop_front();
          if (got.command !== want.command)
            flag_mismatch("lamp_command", want.command, got.command);
          if (got.mode !== want.mode)
            flag_mismatch("lamp_mode", want.mode, got.mode);
          if (got.rate_hz !== want.rate_hz)
            flag_mismatch("strobe_rate_hz", want.rate_hz, got.rate_hz);
        end
      end
      if (ev_if.valid && ev_if.ready)
        expected_lamp_q.push_back(lamp_step(ev_if.kind, ev_if.now_ms));
    end
    if ((res_if.valid && res_if.ready) || (ev_if.valid && ev_if.ready)) stall_cycles = 0;
    else stall_cycles++;
  end

  initial begin : stall_watch
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  task automatic send_event(input logic [1:0] kind, input logic [31:0] stamp);
    while (!steady_flow && $urandom_range(0, 99) < 19) begin
      ev_if.valid <= 1'b0;
      @(posedge clk);
    end
    ev_if.valid  <= 1'b1;
    ev_if.kind   <= kind;
    ev_if.now_ms <= stamp;
    do @(posedge clk); while (ev_if.ready !== 1'b1);
    events_sent++;
  endtask

  task automatic tap_pad(input logic [31:0] stamp);
    send_event(tglc_pkg::KIND_PRESS, stamp);
    send_event(tglc_pkg::KIND_RELEASE, stamp + 32'd10);
  endtask

  // Hold the sender until every pending result is out.
  task automatic settle();
    ev_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_lamp_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [tglc_pkg::CFG_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {16'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (index)
      tglc_pkg::REG_HOLD_TIMEOUT: hold_timeout_cfg = value;
      tglc_pkg::REG_HOLD_REPEAT:  hold_repeat_cfg  = value;
      tglc_pkg::REG_DOUBLE_CLICK: double_click_cfg = value;
      default: ;
    endcase
    // read it straight back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[tglc_pkg::CFG_W-1:0] !== value)
      flag_mismatch("register readback", value, prdata[tglc_pkg::CFG_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(input logic [tglc_pkg::CFG_W-1:0] timeout_ms,
                                input logic [tglc_pkg::CFG_W-1:0] repeat_ms,
                                input logic [tglc_pkg::CFG_W-1:0] double_ms);
    settle();
    write_reg(tglc_pkg::REG_HOLD_TIMEOUT, timeout_ms);
    write_reg(tglc_pkg::REG_HOLD_REPEAT, repeat_ms);
    write_reg(tglc_pkg::REG_DOUBLE_CLICK, double_ms);
  endtask

  task automatic random_gestures(input int count);
    int          stop_at;
    int unsigned pick;
    int unsigned tap_len;
    stop_at = events_sent + count;
    tap_len = double_click_cfg / 4;
    if (hold_timeout_cfg < tap_len) tap_len = hold_timeout_cfg;
    while (events_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_event(tglc_pkg::KIND_BREATHE, wall_ms);
      end else if (pick < 12) begin
        send_event(2'($urandom_range(0, 3)), $urandom());
      end else if (pick < 13) begin
        settle();
      end else if (pick < 15) begin
        // park the clock just short of the wrap
        wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * hold_timeout_cfg);
      end else begin
        wall_ms += ($urandom_range(0, 9) < 7) ? $urandom_range(0, double_click_cfg)
                                               : $urandom_range(0, 4 * double_click_cfg);
        send_event(tglc_pkg::KIND_PRESS, wall_ms);
        if (pick < 55) begin
          // cross the timeout about half the time, sometimes land right on it
          wall_ms += ($urandom_range(0, 7) == 0) ? hold_timeout_cfg
                                                 : $urandom_range(0, 2 * hold_timeout_cfg + 1);
          send_event(tglc_pkg::KIND_TICK, wall_ms);
          repeat ($urandom_range(0, 5)) begin
            wall_ms += $urandom_range(0, 2 * hold_repeat_cfg + 1);
            send_event(tglc_pkg::KIND_TICK, wall_ms);
          end
        end
        wall_ms += $urandom_range(0, tap_len);
        send_event(tglc_pkg::KIND_RELEASE, wall_ms);
      end
    end
  endtask

  task automatic test_gesture_walk();
    // reset timing: tick exactly at the timeout, then just past it
    send_event(tglc_pkg::KIND_PRESS, 32'd1000);
    send_event(tglc_pkg::KIND_TICK, 32'd1500);
    send_event(tglc_pkg::KIND_TICK, 32'd1501);
    send_event(tglc_pkg::KIND_RELEASE, 32'd1550);
    apply_settings(16'd30, 16'd10, 16'd400);
    tap_pad(32'd2000);
    tap_pad(32'd2100);
    tap_pad(32'd2200);
    send_event(tglc_pkg::KIND_PRESS, 32'd2250);
    send_event(tglc_pkg::KIND_TICK, 32'd2281);
    send_event(tglc_pkg::KIND_RELEASE, 32'd2290);
    tap_pad(32'd2300);
    tap_pad(32'd2400);
    // strobe walks the whole rate ladder and wraps
    send_event(tglc_pkg::KIND_PRESS, 32'd2420);
    for (int i = 0; i < 5; i++) send_event(tglc_pkg::KIND_TICK, 32'd2451 + 32'(11 * i));
    send_event(tglc_pkg::KIND_RELEASE, 32'd2500);
    tap_pad(32'd2600);
    tap_pad(32'd2700);
    send_event(tglc_pkg::KIND_PRESS, 32'd2720);
    send_event(tglc_pkg::KIND_TICK, 32'd2751);
    send_event(tglc_pkg::KIND_BREATHE, 32'd2760);
    send_event(tglc_pkg::KIND_TICK, 32'd2765);
    send_event(tglc_pkg::KIND_RELEASE, 32'd2770);
    wall_ms = 32'd3000;
  endtask

  task automatic test_default_timing();
    apply_settings(tglc_pkg::HOLD_TIMEOUT_RST, tglc_pkg::HOLD_REPEAT_RST,
                   tglc_pkg::DOUBLE_CLICK_RST);
    random_gestures(300);
  endtask

  task automatic test_shortest_timing();
    apply_settings(16'd1, 16'd1, 16'd1);
    random_gestures(250);
  endtask

  task automatic test_longest_timing();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_gestures(250);
  endtask

  task automatic test_repeat_over_timeout();
    apply_settings(16'd40, 16'd300, 16'd250);
    random_gestures(250);
  endtask

  task automatic test_random_timing();
    logic [tglc_pkg::CFG_W-1:0] timeout_ms;
    for (int round = 0; round < 3; round++) begin
      timeout_ms = 16'($urandom_range(1, 65535));
      apply_settings(timeout_ms, 16'($urandom_range(1, timeout_ms)),
                     16'($urandom_range(1, 65535)));
      steady_flow = (round == 1);
      random_gestures(180);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst          <= 1'b1;
    ev_if.valid  <= 1'b0;
    ev_if.kind   <= tglc_pkg::KIND_PRESS;
    ev_if.now_ms <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_gesture_walk();
    test_default_timing();
    test_shortest_timing();
    test_longest_timing();
    test_repeat_over_timeout();
    test_random_timing();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_lamp_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/tglc_pkg.sv
hdl/tglc_if.sv
hdl/tglc_regs.sv
hdl/touch_gesture_lamp_controller_unit.sv
verif/touch_gesture_lamp_controller_unit_tb.sv
